// ----- rtl/spm_pkg.sv -----
package spm_pkg;

    localparam int PATTERN_MAX_DEF = 8;
    localparam int BYTE_W          = 8;
    localparam int PATTERN_W       = 64;
    localparam int LEN_W           = 4;
    localparam int CFG_INDEX_W     = 4;

    localparam logic [BYTE_W-1:0]      ASTERISK           = 8'h2A;
    localparam logic [LEN_W-1:0]       LEN_RESET          = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_BYTES  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 4'd1;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              masked;
        logic              last;
    } cell_t;

    typedef struct packed {
        logic en;
        logic sel_in;
        logic mark;
    } cell_ctrl_t;

endpackage

// ----- rtl/spm_cell.sv -----
module spm_cell (
    input  logic               aclk,
    input  spm_pkg::cell_ctrl_t ctrl,
    input  spm_pkg::cell_t     nbr,
    input  spm_pkg::cell_t     ld,
    output spm_pkg::cell_t     q
);
    import spm_pkg::*;

    cell_t data_reg;
    cell_t data_next;

    always_comb begin
        data_next        = ctrl.sel_in ? ld : nbr;
        data_next.masked = data_next.masked | ctrl.mark;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            data_reg <= data_next;
        end
    end

    assign q = data_reg;

endmodule

// ----- rtl/stream_pattern_mask.sv -----
// Byte stream filter that replaces every leftmost, non-overlapping occurrence
// of a configured pattern of one to PATTERN_MAX bytes with asterisks.
// The input channel (s_valid, s_ready, s_in_byte, s_in_last) carries one byte
// per transaction, and s_in_last marks the final byte of a stream.
// The output channel (m_valid, m_ready, m_out_byte, m_out_last) carries exactly
// one byte for every input byte, in order, with m_out_last on the final byte.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// the pattern bytes at index 0 and the pattern length at index 1; it is always
// ready and should be used only while no stream data is in flight.
// Bytes wait in a row of cells until the pattern length is reached; then, while
// the receiver is ready, one byte leaves the front of the row every cycle, so
// the block sustains one byte per cycle on both channels. The first output of
// a stream is registered after the input that fills the window enters the row,
// and the last stream byte flushes the rest one per cycle unless stalled.
// When the receiver stalls, the row keeps accepting bytes until all of its
// PATTERN_MAX cells are occupied, and then s_ready falls.
// Synchronous reset empties the row, drops the output, and restores a zero
// pattern of length one.
module stream_pattern_mask #(
    parameter int PATTERN_MAX = spm_pkg::PATTERN_MAX_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [spm_pkg::BYTE_W-1:0]        s_in_byte,
    input  logic                              s_in_last,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [spm_pkg::BYTE_W-1:0]        m_out_byte,
    output logic                              m_out_last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [spm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [spm_pkg::PATTERN_W-1:0]     cfg_data
);
    import spm_pkg::*;

    localparam int FW = $clog2(PATTERN_MAX + 1);

    logic [PATTERN_W-1:0] pattern_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [FW-1:0]        fill_reg;
    logic [FW-1:0]        fill_next;
    logic                 armed_reg;
    logic                 armed_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [BYTE_W-1:0]    m_byte_reg;
    logic [BYTE_W-1:0]    m_byte_next;
    logic                 m_last_reg;
    logic                 m_last_next;

    cell_t      cell_q   [PATTERN_MAX];
    cell_t      cell_nbr [PATTERN_MAX];
    cell_ctrl_t cell_ctl [PATTERN_MAX];
    cell_t      in_cell;

    logic [FW-1:0] eff_n;
    logic [FW-1:0] avail;
    logic          has_last;
    logic          match;
    logic          front_masked;
    logic          can_check;
    logic          act;
    logic          pop;
    logic          push;
    logic          mark_en;
    logic          cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            len_reg     <= LEN_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_PATTERN_BYTES:  pattern_reg <= cfg_data;
                CFG_PATTERN_LENGTH: len_reg     <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (len_reg == '0) begin
            eff_n = FW'(1);
        end else if (len_reg > LEN_W'(PATTERN_MAX)) begin
            eff_n = FW'(PATTERN_MAX);
        end else begin
            eff_n = FW'(len_reg);
        end
    end

    // The match region never runs past the first stream end in the row.
    always_comb begin
        has_last = 1'b0;
        avail    = fill_reg;
        for (int i = PATTERN_MAX - 1; i >= 0; i--) begin
            if (FW'(i) < fill_reg && cell_q[i].last) begin
                has_last = 1'b1;
                avail    = FW'(i + 1);
            end
        end
    end

    always_comb begin
        match = 1'b1;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if (FW'(k) < eff_n && cell_q[k].data != pattern_reg[8*k +: BYTE_W]) begin
                match = 1'b0;
            end
        end
    end

    assign front_masked = (fill_reg != '0) && cell_q[0].masked;
    assign can_check    = armed_reg && (avail >= eff_n);
    assign act          = front_masked || can_check || has_last;
    assign pop          = act && (!m_valid_reg || m_ready);
    assign s_ready      = (fill_reg < FW'(PATTERN_MAX)) || pop;
    assign push         = s_valid && s_ready;
    assign mark_en      = pop && !front_masked && can_check && match;

    assign in_cell = '{data: s_in_byte, masked: 1'b0, last: s_in_last};

    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            cell_nbr[i] = (i == PATTERN_MAX - 1) ? in_cell : cell_q[(i + 1) % PATTERN_MAX];
            cell_ctl[i].en     = pop || (push && FW'(i) == fill_reg);
            cell_ctl[i].sel_in = pop ? (push && FW'(i) == fill_reg - FW'(1)) : 1'b1;
            cell_ctl[i].mark   = mark_en && ((FW + 1)'(i + 1) < {1'b0, eff_n});
        end
    end

    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
        spm_cell u_cell (
            .aclk (aclk),
            .ctrl (cell_ctl[g]),
            .nbr  (cell_nbr[g]),
            .ld   (in_cell),
            .q    (cell_q[g])
        );
    end

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + FW'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - FW'(1);
        end
        armed_next = armed_reg;
        if (push) begin
            armed_next = 1'b1;
        end else if (cfg_write) begin
            armed_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        if (pop) begin
            m_valid_next = 1'b1;
            m_byte_next  = (front_masked || match) ? ASTERISK : cell_q[0].data;
            if (!front_masked && !can_check) begin
                m_byte_next = cell_q[0].data;
            end
            m_last_next = cell_q[0].last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            armed_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            armed_reg   <= armed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_out_last = m_last_reg;

endmodule

// ----- rtl/spm_checker.sv -----
module spm_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [spm_pkg::BYTE_W-1:0] m_out_byte,
    input logic                       m_out_last
);
    localparam int PEND_W = 16;

    logic [PEND_W-1:0] pend_reg;
    logic [PEND_W-1:0] pend_next;

    always_comb begin
        pend_next = pend_reg;
        if ((s_valid && s_ready) && !(m_valid && m_ready)) begin
            pend_next = pend_reg + PEND_W'(1);
        end else if (!(s_valid && s_ready) && (m_valid && m_ready)) begin
            pend_next = pend_reg - PEND_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // A stalled output transaction keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_out_last))
        else $error("output changed while stalled");

    // The input side only stalls when a full row waits on a stalled receiver.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output back-pressure");

    // Every byte shown on the output stems from an accepted input byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != '0)
        else $error("output byte without a pending input byte");

    // Reset leaves no output pending.
    assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_valid)
        else $error("output valid right after reset");

endmodule

bind stream_pattern_mask spm_checker u_spm_checker (.*);

// ----- tb/tb_stream_pattern_mask.sv -----
module tb_stream_pattern_mask;
    timeunit 1ns;
    timeprecision 1ps;

    import spm_pkg::*;

    localparam int PATTERN_MAX  = PATTERN_MAX_DEF;
    localparam int RANDOM_ITEMS = 410;
    localparam int SETTLE       = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } beat_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [BYTE_W-1:0]      s_in_byte = '0;
    logic                   s_in_last = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [BYTE_W-1:0]      m_out_byte;
    logic                   m_out_last;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [PATTERN_W-1:0]   cfg_data = '0;

    logic [PATTERN_W-1:0] pattern_copy = '0;
    logic [LEN_W-1:0]     length_copy = LEN_RESET;
    logic [BYTE_W-1:0]    held_bytes[$];
    beat_t                raw_q[$];
    beat_t                masked_q[$];
    beat_t                next_beat;
    beat_t                want;
    int                   queued_total = 0;
    int                   mismatches = 0;
    int                   cycle_count = 0;
    int                   send_gap = 0;
    int                   recv_stall = 0;
    logic                 offer_open;
    logic                 no_idle = 1'b0;
    logic                 recv_hold = 1'b0;

    stream_pattern_mask dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic int active_length(input logic [LEN_W-1:0] len);
        if (len == 0) return 1;
        if (len > PATTERN_MAX) return PATTERN_MAX;
        return int'(len);
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic mask_bytes(input logic [BYTE_W-1:0] din, input logic dlast);
        int                n;
        int                k;
        bit                hit;
        logic [BYTE_W-1:0] outs[$];
        beat_t             b;
        n = active_length(length_copy);
        if (held_bytes.size() >= PATTERN_MAX) void'(held_bytes.pop_back());
        held_bytes.push_back(din);
        while (held_bytes.size() >= n) begin
            hit = 1'b1;
            for (k = 0; k < n; k++) begin
                if (held_bytes[k] != pattern_copy[8*k +: 8]) hit = 1'b0;
            end
            if (hit) begin
                for (k = 0; k < n; k++) begin
                    outs.push_back(ASTERISK);
                    void'(held_bytes.pop_front());
                end
            end else begin
                outs.push_back(held_bytes.pop_front());
            end
        end
        if (dlast) begin
            while (held_bytes.size() != 0) outs.push_back(held_bytes.pop_front());
        end
        for (k = 0; k < outs.size(); k++) begin
            b.data = outs[k];
            b.last = dlast && (k == outs.size() - 1);
            masked_q.push_back(b);
        end
    endtask

    task automatic queue_byte(input logic [BYTE_W-1:0] data, input logic last);
        beat_t b;
        b.data = data;
        b.last = last;
        raw_q.push_back(b);
        queued_total++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [PATTERN_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_PATTERN_BYTES) pattern_copy = val;
        else if (idx == CFG_PATTERN_LENGTH) length_copy = val[LEN_W-1:0];
    endtask

    task automatic wait_drained();
        while (raw_q.size() != 0 || s_valid || masked_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic queue_stream(input int target, input bit end_it, input bit noisy);
        int                n;
        int                m;
        int                k;
        int                kind;
        logic [BYTE_W-1:0] body[$];
        n = active_length(length_copy);
        while (body.size() < target) begin
            kind = noisy ? 9 : $urandom_range(0, 9);
            if (kind < 3) begin
                for (k = 0; k < n; k++) body.push_back(pattern_copy[8*k +: 8]);
            end else if (kind < 5) begin
                m = $urandom_range(1, n);
                for (k = 0; k < m; k++) body.push_back(pattern_copy[8*k +: 8]);
            end else if (kind < 8) begin
                k = $urandom_range(0, n - 1);
                body.push_back(pattern_copy[8*k +: 8]);
            end else begin
                body.push_back(BYTE_W'($urandom_range(0, 255)));
            end
        end
        for (k = 0; k < body.size(); k++) begin
            queue_byte(body[k], end_it && (k == body.size() - 1));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            offer_open = !s_valid;
            if (s_valid && s_ready) begin
                mask_bytes(s_in_byte, s_in_last);
                send_gap = no_idle ? 0 : gap_len();
                offer_open = 1'b1;
            end
            if (offer_open) begin
                if (send_gap == 0 && raw_q.size() != 0) begin
                    next_beat = raw_q.pop_front();
                    s_valid   <= 1'b1;
                    s_in_byte <= next_beat.data;
                    s_in_last <= next_beat.last;
                end else begin
                    s_valid <= 1'b0;
                    if (send_gap != 0) send_gap--;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (masked_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected output byte %h last %b",
                                              m_out_byte, m_out_last));
                end else begin
                    want = masked_q.pop_front();
                    if (m_out_byte !== want.data)
                        report_mismatch($sformatf("out_byte %h, expected %h",
                                                  m_out_byte, want.data));
                    if (m_out_last !== want.last)
                        report_mismatch($sformatf("out_last %b, expected %b",
                                                  m_out_last, want.last));
                end
            end
            if (recv_stall != 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else if (recv_hold) begin
                m_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                recv_stall = gap_len();
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int                   phase;
        int                   target;
        int                   r;
        int                   phase_end;
        logic [LEN_W-1:0]     len_val;
        logic [PATTERN_W-1:0] pat;
        logic [PATTERN_W-1:0] len_word;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset configuration: a zero pattern of length one.
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(ASTERISK, 1'b0);
        queue_byte(8'h00, 1'b1);
        wait_drained();

        // A match in the middle of a stream, then a short tail at the end.
        write_reg(CFG_PATTERN_BYTES, 64'h0000_0000_0063_6261);
        write_reg(CFG_PATTERN_LENGTH, {60'h0, 4'd3});
        queue_byte(8'h78, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h62, 1'b0);
        queue_byte(8'h63, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h62, 1'b1);
        wait_drained();

        // A length of zero behaves as one.
        write_reg(CFG_PATTERN_LENGTH, {60'hA5A5_A5A5_A5A5_A5A, 4'd0});
        queue_byte(8'h61, 1'b1);
        wait_drained();

        // A length above the maximum behaves as the maximum.
        write_reg(CFG_PATTERN_BYTES, 64'hFF00_2A55_AA01_807F);
        write_reg(CFG_PATTERN_LENGTH, {60'h0, 4'd15});
        for (int k = 0; k < PATTERN_MAX; k++)
            queue_byte(pattern_copy[8*k +: 8], k == PATTERN_MAX - 1);
        wait_drained();

        // The length shrinks while bytes of an open stream are still held.
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h03, 1'b0);
        queue_byte(8'h04, 1'b0);
        wait_drained();
        write_reg(CFG_PATTERN_LENGTH, {60'hFFFF_FFFF_FFFF_FFF, 4'd2});
        queue_byte(8'h05, 1'b1);
        wait_drained();

        phase = 0;
        phase_end = queued_total + RANDOM_ITEMS;
        while (queued_total < phase_end) begin
            r = $urandom_range(0, 9);
            if (r == 0) len_val = 4'd0;
            else if (r == 1) len_val = LEN_W'($urandom_range(9, 15));
            else if (r <= 3) len_val = 4'd8;
            else if (r <= 5) len_val = 4'd1;
            else len_val = LEN_W'($urandom_range(2, 7));
            r = $urandom_range(0, 9);
            if (r == 0) pat = '1;
            else if (r == 1) pat = '0;
            else if (r <= 4) pat = {$urandom(), $urandom()};
            else begin
                for (int k = 0; k < PATTERN_MAX; k++)
                    pat[8*k +: 8] = 8'h41 + BYTE_W'($urandom_range(0, 2));
            end
            if ($urandom_range(0, 3) != 0) write_reg(CFG_PATTERN_BYTES, pat);
            len_word = {$urandom(), $urandom()};
            len_word[LEN_W-1:0] = len_val;
            write_reg(CFG_PATTERN_LENGTH, len_word);
            no_idle <= ($urandom_range(0, 4) == 0);

            target = (phase == 1) ? 48 : $urandom_range(15, 45);
            target = queued_total + target;
            while (queued_total < target) begin
                queue_stream($urandom_range(1, 24),
                             (queued_total + 24 < target) || ($urandom_range(0, 4) != 0),
                             $urandom_range(0, 6) == 0);
            end

            if (phase == 1) begin
                recv_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                recv_hold <= 1'b0;
            end
            wait_drained();
            phase++;
        end

        no_idle <= 1'b0;
        wait_drained();
        if (mismatches == 0 && masked_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
